@@ src/jsei_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsei_pkg
// Shared constants, types and fixed-point helpers of the joint state
// integrator.
// ----------------------------------------------------------------------------
package jsei_pkg;

  localparam int MAX_BODIES = 256;
  localparam int NPOS       = 7;
  localparam int NVEL       = 6;
  localparam int POS_DEPTH  = MAX_BODIES * NPOS;
  localparam int VEL_DEPTH  = MAX_BODIES * NVEL;
  localparam int POS_AW     = $clog2(POS_DEPTH);
  localparam int VEL_AW     = $clog2(VEL_DEPTH);
  localparam int ACC_W      = 52;
  localparam int NUM_W      = 48;

  localparam logic [30:0] STEP_RESET = 31'd655;

  // command codes
  localparam logic [1:0] CMD_LOAD_POS  = 2'd0;
  localparam logic [1:0] CMD_LOAD_VEL  = 2'd1;
  localparam logic [1:0] CMD_INTEGRATE = 2'd2;
  localparam logic [1:0] CMD_RESERVED  = 2'd3;

  // joint types
  localparam logic [2:0] DOF_FREE   = 3'd0;
  localparam logic [2:0] DOF_SLIDER = 3'd1;
  localparam logic [2:0] DOF_HINGE  = 3'd2;
  localparam logic [2:0] DOF_FIXED  = 3'd3;
  localparam logic [2:0] DOF_BALL   = 3'd4;

  // one product of the quaternion rate
  typedef struct packed {
    logic [1:0] qc;    // quaternion component
    logic [1:0] oc;    // angular velocity component
    logic [1:0] term;  // rate term it goes into
    logic       neg;   // subtracted
  } qprod_t;

  // omega (x) q, three products per term
  function automatic qprod_t qprod(input logic [3:0] m);
    qprod_t r;
    unique case (m)
      4'd0:    r = '{qc: 2'd1, oc: 2'd0, term: 2'd0, neg: 1'b1};
      4'd1:    r = '{qc: 2'd2, oc: 2'd1, term: 2'd0, neg: 1'b1};
      4'd2:    r = '{qc: 2'd3, oc: 2'd2, term: 2'd0, neg: 1'b1};
      4'd3:    r = '{qc: 2'd0, oc: 2'd0, term: 2'd1, neg: 1'b0};
      4'd4:    r = '{qc: 2'd3, oc: 2'd1, term: 2'd1, neg: 1'b0};
      4'd5:    r = '{qc: 2'd2, oc: 2'd2, term: 2'd1, neg: 1'b1};
      4'd6:    r = '{qc: 2'd3, oc: 2'd0, term: 2'd2, neg: 1'b1};
      4'd7:    r = '{qc: 2'd0, oc: 2'd1, term: 2'd2, neg: 1'b0};
      4'd8:    r = '{qc: 2'd1, oc: 2'd2, term: 2'd2, neg: 1'b0};
      4'd9:    r = '{qc: 2'd2, oc: 2'd0, term: 2'd3, neg: 1'b0};
      4'd10:   r = '{qc: 2'd1, oc: 2'd1, term: 2'd3, neg: 1'b1};
      4'd11:   r = '{qc: 2'd0, oc: 2'd2, term: 2'd3, neg: 1'b0};
      default: r = '{qc: 2'd0, oc: 2'd0, term: 2'd0, neg: 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // round to nearest, ties upward
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    return (p + 66'sd32768) >>> 16;
  endfunction

  function automatic logic signed [65:0] rnd17(input logic signed [65:0] p);
    return (p + 66'sd65536) >>> 17;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-{1'b0, v}) : v;
  endfunction

endpackage

@@ src/joint_state_euler_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_state_euler_integrator
// Symplectic Euler integrator over per-body position and velocity memories
// with quaternion advance and renormalisation.
// ----------------------------------------------------------------------------
// One command is handled at a time. A load is written in the cycle it is
// accepted. An integrate command reads the body's thirteen words, passes
// each velocity and each linear position through the shared 33x33
// multiplier, then emits one result per cycle while the output does not
// stall, writing each result back. The quaternion of a ball or free body
// adds a wait on the square root unit and, for a non-zero norm, four
// divisions.
module joint_state_euler_integrator
  import jsei_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         body_index,
  input  logic [2:0]         coord_index,
  input  logic signed [31:0] load_value,
  input  logic [2:0]         dof_type,
  input  logic signed [31:0] accel_0,
  input  logic signed [31:0] accel_1,
  input  logic signed [31:0] accel_2,
  input  logic signed [31:0] accel_3,
  input  logic signed [31:0] accel_4,
  input  logic signed [31:0] accel_5,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_body,
  output logic               coord_kind,
  output logic [2:0]         out_coord,
  output logic signed [31:0] out_value,
  output logic               last
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_READ   = 17'b00000000000000010,
    S_VMUL   = 17'b00000000000000100,
    S_VACC   = 17'b00000000000001000,
    S_LMUL   = 17'b00000000000010000,
    S_LACC   = 17'b00000000000100000,
    S_QMUL   = 17'b00000000001000000,
    S_QACC   = 17'b00000000010000000,
    S_HMUL   = 17'b00000000100000000,
    S_HACC   = 17'b00000001000000000,
    S_SQMUL  = 17'b00000010000000000,
    S_SQACC  = 17'b00000100000000000,
    S_ROOT   = 17'b00001000000000000,
    S_RWAIT  = 17'b00010000000000000,
    S_DIV    = 17'b00100000000000000,
    S_DWAIT  = 17'b01000000000000000,
    S_EMIT   = 17'b10000000000000000
  } state_t;

  state_t state;

  logic [30:0]              h;
  logic [7:0]               body;
  logic                     is_free;
  logic                     is_ball;
  logic [3:0]               nv;
  logic [3:0]               total;
  logic [3:0]               idx;
  logic signed [31:0]       accel [NVEL];
  logic signed [31:0]       vreg [NVEL];
  logic signed [31:0]       preg [NPOS];
  logic signed [ACC_W-1:0]  acc [4];
  logic [63:0]              ssum;
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       prod;
  logic                     in_fire;
  logic                     emit_go;
  logic                     emit_last;
  logic [2:0]               qb;
  logic [2:0]               ob;
  qprod_t                   qp;
  logic [2:0]               qidx;
  logic [2:0]               pidx;
  logic [2:0]               rd_coord;
  logic [2:0]               vel_coord;
  logic [2:0]               pos_coord;
  logic [7:0]               body_sel;
  logic [POS_AW-1:0]        pos_addr;
  logic [VEL_AW-1:0]        vel_addr;
  logic                     pos_we;
  logic                     vel_we;
  logic signed [31:0]       pos_wdata;
  logic signed [31:0]       vel_wdata;
  logic [31:0]              pos_rdata;
  logic [31:0]              vel_rdata;
  logic                     root_busy;
  logic                     root_done;
  logic [31:0]              root_n;
  logic                     div_busy;
  logic                     div_done;
  logic [NUM_W-1:0]         div_q;
  logic [NUM_W-1:0]         div_num;
  logic signed [31:0]       cq;
  logic [31:0]              cq_mag;
  logic signed [32:0]       qsig;
  logic signed [65:0]       prod_r16;
  logic signed [31:0]       acc_sat;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign emit_last = (idx == total - 4'd1);

  assign qb   = is_free ? 3'd3 : 3'd0;
  assign ob   = is_free ? 3'd3 : 3'd0;
  assign qp   = qprod(idx);
  assign pidx = 3'(idx - nv);

  // quaternion word in focus for square, divide and rate update
  assign qidx   = qb + 3'(idx[1:0]);
  assign cq     = preg[qidx];
  assign cq_mag = mag32(cq);
  assign prod_r16 = rnd16(prod);

  // rate term in focus, saturated to 32 bits
  assign acc_sat = sat32({{(66-ACC_W){acc[idx[1:0]][ACC_W-1]}}, acc[idx[1:0]]});

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      h <= STEP_RESET;
    end else if (cfg_write) begin
      h <= cfg_data;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = {2'b00, h};
    mul_b = '0;
    unique case (state)
      S_VMUL:  mul_b = {accel[idx[2:0]][31], accel[idx[2:0]]};
      S_LMUL:  mul_b = {vreg[idx[2:0]][31], vreg[idx[2:0]]};
      S_QMUL: begin
        mul_a = {preg[qb + 3'(qp.qc)][31], preg[qb + 3'(qp.qc)]};
        mul_b = {vreg[ob + 3'(qp.oc)][31], vreg[ob + 3'(qp.oc)]};
      end
      S_HMUL: begin
        mul_b = {acc_sat[31], acc_sat};
      end
      S_SQMUL: begin
        mul_a = {1'b0, cq_mag};
        mul_b = {1'b0, cq_mag};
      end
      default: mul_b = '0;
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memory addressing
  assign body_sel  = (state == S_IDLE) ? body_index : body;
  assign rd_coord  = 3'(idx);
  assign vel_coord = (state == S_IDLE) ? coord_index :
                     (state == S_EMIT) ? 3'(idx) :
                     ((rd_coord > 3'd5) ? 3'd5 : rd_coord);
  assign pos_coord = (state == S_IDLE) ? coord_index :
                     (state == S_EMIT) ? pidx : rd_coord;
  assign pos_addr  = POS_AW'(({3'b000, body_sel} << 3) - {3'b000, body_sel})
                     + POS_AW'(pos_coord);
  assign vel_addr  = VEL_AW'(({3'b000, body_sel} << 2) + ({3'b000, body_sel} << 1))
                     + VEL_AW'(vel_coord);

  // write back from load commands and from the emit sweep
  assign pos_we = (in_fire && command == CMD_LOAD_POS && coord_index < 3'(NPOS)) ||
                  (emit_go && idx >= nv);
  assign vel_we = (in_fire && command == CMD_LOAD_VEL && coord_index < 3'(NVEL)) ||
                  (emit_go && idx < nv);
  assign pos_wdata = (state == S_IDLE) ? load_value : preg[pidx];
  assign vel_wdata = (state == S_IDLE) ? load_value : vreg[idx[2:0]];

  jsei_ram #(.WIDTH(32), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .addr  (pos_addr),
    .wdata (pos_wdata),
    .rdata (pos_rdata)
  );

  jsei_ram #(.WIDTH(32), .DEPTH(VEL_DEPTH)) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .addr  (vel_addr),
    .wdata (vel_wdata),
    .rdata (vel_rdata)
  );

  // norm and renormalisation units
  jsei_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_ROOT),
    .radicand (ssum),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root_n)
  );

  assign div_num = NUM_W'({cq_mag, 15'b0}) + NUM_W'(root_n >> 1);

  jsei_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV),
    .num   (div_num),
    .den   (root_n),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // clamp quotient to 2^31
  assign qsig = (div_q > NUM_W'(33'h080000000)) ? 33'sh080000000 : {1'b0, div_q[31:0]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_fire && command == CMD_INTEGRATE &&
              (dof_type == DOF_FREE || dof_type == DOF_BALL ||
               dof_type == DOF_SLIDER || dof_type == DOF_HINGE)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (idx == 4'd7) begin
            idx   <= '0;
            state <= S_VMUL;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        S_VMUL: state <= S_VACC;
        S_VACC: begin
          if (idx == nv - 4'd1) begin
            idx   <= '0;
            state <= is_ball ? S_QMUL : S_LMUL;
          end else begin
            idx   <= idx + 4'd1;
            state <= S_VMUL;
          end
        end
        S_LMUL: state <= S_LACC;
        S_LACC: begin
          if (is_free && idx < 4'd2) begin
            idx   <= idx + 4'd1;
            state <= S_LMUL;
          end else begin
            idx   <= '0;
            state <= is_free ? S_QMUL : S_EMIT;
          end
        end
        S_QMUL: state <= S_QACC;
        S_QACC: begin
          if (idx == 4'd11) begin
            idx   <= '0;
            state <= S_HMUL;
          end else begin
            idx   <= idx + 4'd1;
            state <= S_QMUL;
          end
        end
        S_HMUL: state <= S_HACC;
        S_HACC: begin
          idx   <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
          state <= (idx == 4'd3) ? S_SQMUL : S_HMUL;
        end
        S_SQMUL: state <= S_SQACC;
        S_SQACC: begin
          idx   <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
          state <= (idx == 4'd3) ? S_ROOT : S_SQMUL;
        end
        S_ROOT: state <= S_RWAIT;
        S_RWAIT: begin
          if (root_done) begin
            state <= (root_n == '0) ? S_EMIT : S_DIV;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            idx   <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
            state <= (idx == 4'd3) ? S_EMIT : S_DIV;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            idx <= idx + 4'd1;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      body     <= body_index;
      is_free  <= (dof_type == DOF_FREE);
      is_ball  <= (dof_type == DOF_BALL);
      nv       <= (dof_type == DOF_FREE) ? 4'd6 : (dof_type == DOF_BALL) ? 4'd3 : 4'd1;
      total    <= (dof_type == DOF_FREE) ? 4'd13 : (dof_type == DOF_BALL) ? 4'd7 : 4'd2;
      accel[0] <= accel_0;
      accel[1] <= accel_1;
      accel[2] <= accel_2;
      accel[3] <= accel_3;
      accel[4] <= accel_4;
      accel[5] <= accel_5;
    end
  end

  // working copy of the body's words
  always_ff @(posedge clk) begin
    unique case (state)
      S_READ: begin
        if (idx != 4'd0) begin
          preg[3'(idx - 4'd1)] <= pos_rdata;
          if (idx <= 4'd6) begin
            vreg[3'(idx - 4'd1)] <= vel_rdata;
          end
        end
        acc[0] <= '0;
        acc[1] <= '0;
        acc[2] <= '0;
        acc[3] <= '0;
        ssum   <= '0;
      end
      S_VACC: vreg[idx[2:0]] <= sat32(sx32(vreg[idx[2:0]]) + sx32(sat32(prod_r16)));
      S_LACC: preg[idx[2:0]] <= sat32(sx32(preg[idx[2:0]]) + sx32(sat32(prod_r16)));
      S_QACC: begin
        if (qp.neg) begin
          acc[qp.term] <= acc[qp.term] - prod_r16[ACC_W-1:0];
        end else begin
          acc[qp.term] <= acc[qp.term] + prod_r16[ACC_W-1:0];
        end
      end
      S_HACC: preg[qidx] <= sat32(sx32(cq) + sx32(sat32(rnd17(prod))));
      S_SQACC: ssum <= ssum + (64'(prod) >> 2);
      S_DWAIT: begin
        if (div_done) begin
          preg[qidx] <= sat32(cq[31] ? -{{33{qsig[32]}}, qsig} : {{33{qsig[32]}}, qsig});
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_body   <= body;
      last       <= emit_last;
      if (idx < nv) begin
        coord_kind <= 1'b1;
        out_coord  <= 3'(idx);
        out_value  <= vreg[idx[2:0]];
      end else begin
        coord_kind <= 1'b0;
        out_coord  <= pidx;
        out_value  <= preg[pidx];
      end
    end
  end

  // divider only ever sees a non-zero norm
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (root_n != '0))
    else $error("divide started with zero norm");

  // root and divide units are free when the root unit is started
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> !root_busy && !div_busy)
    else $error("root unit started while busy");

  // final result returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_last) |=> (state == S_IDLE) && out_valid && last)
    else $error("final result did not close the command");

endmodule

@@ src/jsei_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsei_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module jsei_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/jsei_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsei_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module jsei_isqrt
  import jsei_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  assign rem_sh = {rem[31:0], x[63:62]};
  assign trial  = {root, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one root digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= {x[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

@@ src/jsei_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsei_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jsei_div
  import jsei_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [32:0] rem;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;

  assign rem_sh = {rem[31:0], quo[NUM_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule
